[rtl/wdpc_pkg.sv]
`default_nettype none

package wdpc_pkg;

    // cordic datapath widths
    localparam int CW       = 30;
    localparam int ZW       = 23;
    localparam int ATAN_LEN = 20;
    // doubled predictions (half units of 1/256 inch)
    localparam int PW       = 21;
    // scaled distance reading, 1/256 inch
    localparam int DW       = 18;
    // config address width
    localparam int AW       = 5;

    // 256 / 25.4 in Q16
    localparam logic [19:0] MM_SCALE_Q16 = 20'd660520;

    localparam logic signed [ZW-1:0] ATAN_Q20 [ATAN_LEN] = '{
        23'sd823550, 23'sd486171, 23'sd256879, 23'sd130396, 23'sd65451,
        23'sd32757,  23'sd16383,  23'sd8192,   23'sd4096,   23'sd2048,
        23'sd1024,   23'sd512,    23'sd256,    23'sd128,    23'sd64,
        23'sd32,     23'sd16,     23'sd8,      23'sd4,      23'sd2
    };

    typedef enum logic [2:0] {
        REG_SENSOR_SPACING = 3'd0,
        REG_FRONT_Y_OFFSET = 3'd1,
        REG_LEFT_X_OFFSET  = 3'd2,
        REG_RIGHT_X_OFFSET = 3'd3,
        REG_FIELD_WIDTH    = 3'd4,
        REG_FIELD_HEIGHT   = 3'd5,
        REG_MAX_DISTANCE   = 3'd6,
        REG_MAX_CORRECTION = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [15:0] pose_x;
        logic signed [15:0] pose_y;
        logic signed [15:0] pose_heading;
        logic [13:0]        front_left_mm;
        logic [13:0]        front_right_mm;
        logic [13:0]        left_mm;
        logic [13:0]        right_mm;
    } t_in;

    typedef struct packed {
        logic signed [15:0] new_x;
        logic signed [15:0] new_y;
        logic signed [15:0] new_heading;
        logic               rejected;
    } t_out;

    // pose and predictions that ride alongside the cordic chain
    typedef struct packed {
        logic signed [15:0]   pose_x;
        logic signed [15:0]   pose_y;
        logic signed [15:0]   pose_heading;
        logic                 front_ok;
        logic                 left_ok;
        logic                 right_ok;
        logic signed [PW-1:0] pred_y2;
        logic signed [PW-1:0] pred_xl2;
        logic signed [PW-1:0] pred_xr2;
    } t_side;

endpackage

`default_nettype wire

[rtl/wdpc_cordic.sv]
`default_nettype none

module wdpc_cordic
    import wdpc_pkg::*;
#(
    parameter int STEPS = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  t_side                i_side,
    output logic                 o_valid,
    output logic signed [ZW-1:0] o_z,
    output t_side                o_side
);

    logic signed [CW-1:0] r_x    [STEPS];
    logic signed [CW-1:0] r_y    [STEPS];
    logic signed [ZW-1:0] r_z    [STEPS];
    logic                 r_v    [STEPS];
    t_side                r_side [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic signed [CW-1:0] x_in;
        logic signed [CW-1:0] y_in;
        logic signed [ZW-1:0] z_in;
        logic                 v_in;
        t_side                s_in;
        logic signed [CW-1:0] n_x;
        logic signed [CW-1:0] n_y;
        logic signed [ZW-1:0] n_z;

        if (k == 0) begin : g_first
            assign x_in = i_x;
            assign y_in = i_y;
            assign z_in = '0;
            assign v_in = i_valid;
            assign s_in = i_side;
        end else begin : g_next
            assign x_in = r_x[k-1];
            assign y_in = r_y[k-1];
            assign z_in = r_z[k-1];
            assign v_in = r_v[k-1];
            assign s_in = r_side[k-1];
        end

        // rotate toward the x axis, floor shifts
        always_comb begin
            if (!y_in[CW-1]) begin
                n_x = x_in + (y_in >>> k);
                n_y = y_in - (x_in >>> k);
                n_z = z_in + ATAN_Q20[k];
            end else begin
                n_x = x_in - (y_in >>> k);
                n_y = y_in + (x_in >>> k);
                n_z = z_in - ATAN_Q20[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= n_x;
                r_y[k]    <= n_y;
                r_z[k]    <= n_z;
                r_side[k] <= s_in;
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_z     = r_z[STEPS-1];
    assign o_side  = r_side[STEPS-1];

endmodule

`default_nettype wire

[rtl/wall_distance_pose_corrector.sv]
// channel  direction  handshake                      payload
// in       input      i_in_valid / o_in_stall        i_in_data (t_in)
// out      output     o_out_valid / i_out_stall      o_out_data (t_out)
// cfg      input      psel penable pwrite / pready   paddr, pwdata, prdata
//
// one transaction per cycle on in and out while the output is not stalled; a result passes through
// scaling, setup, the cordic chain (one stage per iteration), acceptance, two blend stages
// and the output register
// synchronous active-low reset clears the valid bits, including the skid valid, and sets the config
// registers to their defaults
// a stalled output freezes every stage; one more input transaction is held in a skid register
`default_nettype none

module wall_distance_pose_corrector
    import wdpc_pkg::*;
#(
    parameter int BLEND_Q8     = 64,
    parameter int CORDIC_STEPS = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  t_in           i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output t_out          o_out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [AW-1:0] paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam logic signed [9:0] W_CUR  = 10'(256 - BLEND_Q8);
    localparam logic signed [9:0] W_PRED = 10'(BLEND_Q8);
    localparam int NW = 23;

    function automatic logic [DW-1:0] mm_to_q8(input logic [13:0] mm);
        logic [33:0] p;
        p = 34'(mm) * 34'(MM_SCALE_Q16) + 34'd32768;
        return p[33:16];
    endfunction

    // ---------------- configuration ----------------
    logic signed [14:0] r_sensor_spacing;
    logic signed [14:0] r_front_y_offset;
    logic signed [14:0] r_left_x_offset;
    logic signed [14:0] r_right_x_offset;
    logic [15:0]        r_field_width;
    logic [15:0]        r_field_height;
    logic [15:0]        r_max_distance;
    logic [15:0]        r_max_correction;
    logic               cfg_wr;
    t_reg_idx           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_spacing <= 15'sd2560;
            r_front_y_offset <= '0;
            r_left_x_offset  <= '0;
            r_right_x_offset <= '0;
            r_field_width    <= 16'd36864;
            r_field_height   <= 16'd36864;
            r_max_distance   <= 16'd12288;
            r_max_correction <= 16'd1024;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SENSOR_SPACING: r_sensor_spacing <= pwdata[14:0];
                REG_FRONT_Y_OFFSET: r_front_y_offset <= pwdata[14:0];
                REG_LEFT_X_OFFSET:  r_left_x_offset  <= pwdata[14:0];
                REG_RIGHT_X_OFFSET: r_right_x_offset <= pwdata[14:0];
                REG_FIELD_WIDTH:    r_field_width    <= pwdata[15:0];
                REG_FIELD_HEIGHT:   r_field_height   <= pwdata[15:0];
                REG_MAX_DISTANCE:   r_max_distance   <= pwdata[15:0];
                REG_MAX_CORRECTION: r_max_correction <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SENSOR_SPACING: prdata = 32'(r_sensor_spacing);
            REG_FRONT_Y_OFFSET: prdata = 32'(r_front_y_offset);
            REG_LEFT_X_OFFSET:  prdata = 32'(r_left_x_offset);
            REG_RIGHT_X_OFFSET: prdata = 32'(r_right_x_offset);
            REG_FIELD_WIDTH:    prdata = 32'(r_field_width);
            REG_FIELD_HEIGHT:   prdata = 32'(r_field_height);
            REG_MAX_DISTANCE:   prdata = 32'(r_max_distance);
            REG_MAX_CORRECTION: prdata = 32'(r_max_correction);
            default:            prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    logic adv;
    logic in_accept;
    logic r_skid_valid;
    t_in  r_skid;
    logic r_out_valid;
    t_out r_out;

    assign adv         = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (adv) begin
            r_skid_valid <= 1'b0;
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!adv && in_accept) begin
            r_skid <= i_in_data;
        end
    end

    // ---------------- stage 1: scale readings ----------------
    t_in           s1_src;
    logic          r_s1_valid;
    t_in           r_s1;
    logic [DW-1:0] r_s1_fl;
    logic [DW-1:0] r_s1_fr;
    logic [DW-1:0] r_s1_dl;
    logic [DW-1:0] r_s1_dr;

    assign s1_src = r_skid_valid ? r_skid : i_in_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= r_skid_valid || i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1    <= s1_src;
            r_s1_fl <= mm_to_q8(s1_src.front_left_mm);
            r_s1_fr <= mm_to_q8(s1_src.front_right_mm);
            r_s1_dl <= mm_to_q8(s1_src.left_mm);
            r_s1_dr <= mm_to_q8(s1_src.right_mm);
        end
    end

    // ---------------- stage 2: predictions and cordic setup ----------------
    logic signed [PW-1:0] fl_s, fr_s, dl_s, dr_s, fh_s, fw_s;
    logic signed [18:0]   diff_f;
    logic signed [15:0]   sx;
    logic signed [18:0]   sy;
    logic                 spacing_neg;
    t_side                s2_side;
    logic                 r_s2_valid;
    logic signed [CW-1:0] r_s2_x;
    logic signed [CW-1:0] r_s2_y;
    t_side                r_s2_side;

    assign fl_s        = $signed(PW'(r_s1_fl));
    assign fr_s        = $signed(PW'(r_s1_fr));
    assign dl_s        = $signed(PW'(r_s1_dl));
    assign dr_s        = $signed(PW'(r_s1_dr));
    assign fh_s        = $signed(PW'(r_field_height));
    assign fw_s        = $signed(PW'(r_field_width));
    assign diff_f      = $signed({1'b0, r_s1_fl}) - $signed({1'b0, r_s1_fr});
    assign spacing_neg = r_sensor_spacing[14];
    // fold so the spacing is positive
    assign sx          = spacing_neg ? -16'(r_sensor_spacing) : 16'(r_sensor_spacing);
    assign sy          = spacing_neg ? -diff_f : diff_f;

    always_comb begin
        s2_side.pose_x       = r_s1.pose_x;
        s2_side.pose_y       = r_s1.pose_y;
        s2_side.pose_heading = r_s1.pose_heading;
        s2_side.front_ok     = (r_s1_fl < DW'(r_max_distance))
                            && (r_s1_fr < DW'(r_max_distance))
                            && (r_sensor_spacing != '0);
        s2_side.left_ok      = r_s1_dl < DW'(r_max_distance);
        s2_side.right_ok     = r_s1_dr < DW'(r_max_distance);
        s2_side.pred_y2      = fh_s - fl_s - fr_s - (PW'(r_front_y_offset) <<< 1);
        s2_side.pred_xl2     = (dl_s <<< 1) + (PW'(r_left_x_offset) <<< 1) - fw_s;
        s2_side.pred_xr2     = fw_s - (dr_s <<< 1) - (PW'(r_right_x_offset) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_x    <= CW'(sx) <<< 8;
            r_s2_y    <= CW'(sy) <<< 8;
            r_s2_side <= s2_side;
        end
    end

    // ---------------- cordic chain ----------------
    logic                 c_valid;
    logic signed [ZW-1:0] c_z;
    t_side                c_side;

    wdpc_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_s2_valid),
        .i_x     (r_s2_x),
        .i_y     (r_s2_y),
        .i_side  (r_s2_side),
        .o_valid (c_valid),
        .o_z     (c_z),
        .o_side  (c_side)
    );

    // ---------------- post 1: acceptance and angle rounding ----------------
    logic signed [PW:0]   mc2, py2, px2, dy, dxl, dxr;
    logic signed [ZW:0]   z_rnd;
    logic                 acc_l, acc_r;
    logic                 r_p1_valid;
    t_side                r_p1_side;
    logic                 r_p1_acc_y;
    logic                 r_p1_acc_x;
    logic signed [PW-1:0] r_p1_pred_x2;
    logic signed [15:0]   r_p1_th;

    assign mc2   = $signed((PW+1)'({r_max_correction, 1'b0}));
    assign py2   = (PW+1)'(c_side.pose_y) <<< 1;
    assign px2   = (PW+1)'(c_side.pose_x) <<< 1;
    assign dy    = (PW+1)'(c_side.pred_y2) - py2;
    assign dxl   = (PW+1)'(c_side.pred_xl2) - px2;
    assign dxr   = (PW+1)'(c_side.pred_xr2) - px2;
    assign acc_l = c_side.left_ok && (dxl < mc2) && (dxl > -mc2);
    assign acc_r = c_side.right_ok && (dxr < mc2) && (dxr > -mc2);
    assign z_rnd = (ZW+1)'(c_z) + (ZW+1)'(128);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (adv) begin
            r_p1_valid <= c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_side    <= c_side;
            r_p1_acc_y   <= c_side.front_ok && (dy < mc2) && (dy > -mc2);
            r_p1_acc_x   <= acc_l || acc_r;
            // right wins over left
            r_p1_pred_x2 <= acc_r ? c_side.pred_xr2 : c_side.pred_xl2;
            r_p1_th      <= 16'(z_rnd >>> 8);
        end
    end

    // ---------------- post 2: blend products ----------------
    logic               r_p2_valid;
    t_side              r_p2_side;
    logic               r_p2_acc_y;
    logic               r_p2_acc_x;
    logic signed [31:0] r_p2_cy, r_p2_py, r_p2_cx, r_p2_px, r_p2_ch, r_p2_ph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else if (adv) begin
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p2_side  <= r_p1_side;
            r_p2_acc_y <= r_p1_acc_y;
            r_p2_acc_x <= r_p1_acc_x;
            r_p2_cy    <= (32'(r_p1_side.pose_y) <<< 1) * 32'(W_CUR);
            r_p2_py    <= 32'(r_p1_side.pred_y2) * 32'(W_PRED);
            r_p2_cx    <= (32'(r_p1_side.pose_x) <<< 1) * 32'(W_CUR);
            r_p2_px    <= 32'(r_p1_pred_x2) * 32'(W_PRED);
            r_p2_ch    <= 32'(r_p1_side.pose_heading) * 32'(W_CUR);
            r_p2_ph    <= 32'(r_p1_th) * 32'(W_PRED);
        end
    end

    // ---------------- post 3: blend sums ----------------
    logic signed [31:0]   sum_y, sum_x, sum_h;
    logic                 r_p3_valid;
    t_side                r_p3_side;
    logic signed [NW-1:0] r_p3_nx;
    logic signed [NW-1:0] r_p3_ny;
    logic signed [15:0]   r_p3_nh;

    assign sum_y = r_p2_cy + r_p2_py + 32'sd256;
    assign sum_x = r_p2_cx + r_p2_px + 32'sd256;
    assign sum_h = r_p2_ch + r_p2_ph + 32'sd128;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_valid <= 1'b0;
        end else if (adv) begin
            r_p3_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p3_side <= r_p2_side;
            r_p3_ny   <= r_p2_acc_y ? sum_y[31:9] : NW'(r_p2_side.pose_y);
            r_p3_nh   <= r_p2_acc_y ? sum_h[23:8] : r_p2_side.pose_heading;
            r_p3_nx   <= r_p2_acc_x ? sum_x[31:9] : NW'(r_p2_side.pose_x);
        end
    end

    // ---------------- output: bounds check ----------------
    logic signed [NW:0] nx2, ny2, fw_b, fh_b;
    logic               rej;

    assign nx2  = (NW+1)'(r_p3_nx) <<< 1;
    assign ny2  = (NW+1)'(r_p3_ny) <<< 1;
    assign fw_b = $signed((NW+1)'(r_field_width));
    assign fh_b = $signed((NW+1)'(r_field_height));
    assign rej  = (nx2 < -fw_b) || (nx2 > fw_b) || (ny2 < -fh_b) || (ny2 > fh_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_p3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.new_x       <= rej ? r_p3_side.pose_x : r_p3_nx[15:0];
            r_out.new_y       <= rej ? r_p3_side.pose_y : r_p3_ny[15:0];
            r_out.new_heading <= rej ? r_p3_side.pose_heading : r_p3_nh;
            r_out.rejected    <= rej;
        end
    end

`ifndef SYNTHESIS
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && adv) |=> !r_skid_valid)
        else $error("skid register did not drain when pipeline advanced");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !adv) |=> (r_skid_valid && r_skid == $past(i_in_data)))
        else $error("transaction taken during freeze not held in skid");

    a_freeze_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!adv && r_p3_valid) |=> r_p3_valid)
        else $error("frozen pipeline dropped a transaction");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_p3_valid))
        else $error("output valid without a transaction in the last blend stage");
`endif

endmodule

`default_nettype wire

[bench/pose_correction_checker.sv]
`timescale 1ns / 1ps

module pose_correction_checker
    import wdpc_pkg::*;
#(
    parameter int BLEND_Q8     = 64,
    parameter int CORDIC_STEPS = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          o_in_stall,
    input  t_in           i_in_data,
    input  logic          o_out_valid,
    input  logic          i_out_stall,
    input  t_out          o_out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic          pready,
    input  logic [AW-1:0] paddr,
    input  logic [31:0]   pwdata,
    output int            fail_count,
    output int            pending,
    output int            checked,
    output int            rejected_seen
);

    longint spacing_r;
    longint front_off_r;
    longint left_off_r;
    longint right_off_r;
    longint width_r;
    longint height_r;
    longint max_dist_r;
    longint max_corr_r;

    t_out expected_poses[$];

    function automatic longint atan_step(int i);
        case (i)
            0:       return 823550;
            1:       return 486171;
            2:       return 256879;
            3:       return 130396;
            4:       return 65451;
            5:       return 32757;
            6:       return 16383;
            7:       return 8192;
            8:       return 4096;
            9:       return 2048;
            10:      return 1024;
            11:      return 512;
            12:      return 256;
            13:      return 128;
            14:      return 64;
            15:      return 32;
            16:      return 16;
            17:      return 8;
            18:      return 4;
            default: return 2;
        endcase
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // mm to 1/256 inch, rounded
    function automatic longint mm_to_q8(logic [13:0] mm);
        return (longint'(mm) * 660520 + 32768) >>> 16;
    endfunction

    // heading of the wall seen by the front pair, q12 radians; sx is positive
    function automatic longint wall_angle(longint sx, longint sy);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = sx * 256;
        y = sy * 256;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 20; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + atan_step(i);
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - atan_step(i);
            end
        end
        return (z + 128) >>> 8;
    endfunction

    // cur2 and pred2 in half units
    function automatic longint blend_half(longint cur2, longint pred2);
        return (cur2 * (256 - BLEND_Q8) + pred2 * BLEND_Q8 + 256) >>> 9;
    endfunction

    function automatic t_out correct_pose(t_in f);
        longint px;
        longint py;
        longint ph;
        longint fl;
        longint fr;
        longint dl;
        longint dr;
        longint nx;
        longint ny;
        longint nh;
        longint sx;
        longint sy;
        longint ang;
        longint pred2;
        logic   rej;
        t_out   r;
        px = longint'($signed(f.pose_x));
        py = longint'($signed(f.pose_y));
        ph = longint'($signed(f.pose_heading));
        fl = mm_to_q8(f.front_left_mm);
        fr = mm_to_q8(f.front_right_mm);
        dl = mm_to_q8(f.left_mm);
        dr = mm_to_q8(f.right_mm);
        nx = px;
        ny = py;
        nh = ph;

        if (fl < max_dist_r && fr < max_dist_r && spacing_r != 0) begin
            sx = spacing_r;
            sy = fl - fr;
            // fold signs so the spacing is positive
            if (sx < 0) begin
                sx = -sx;
                sy = -sy;
            end
            ang = wall_angle(sx, sy);
            pred2 = height_r - (fl + fr) - 2 * front_off_r;
            if (mag(pred2 - 2 * py) < 2 * max_corr_r) begin
                ny = blend_half(2 * py, pred2);
                nh = (ph * (256 - BLEND_Q8) + ang * BLEND_Q8 + 128) >>> 8;
            end
        end

        if (dl < max_dist_r) begin
            pred2 = -width_r + 2 * dl + 2 * left_off_r;
            if (mag(pred2 - 2 * px) < 2 * max_corr_r)
                nx = blend_half(2 * px, pred2);
        end

        // right side overrides left when both are accepted
        if (dr < max_dist_r) begin
            pred2 = width_r - 2 * dr - 2 * right_off_r;
            if (mag(pred2 - 2 * px) < 2 * max_corr_r)
                nx = blend_half(2 * px, pred2);
        end

        rej = (2 * nx < -width_r) || (2 * nx > width_r) ||
              (2 * ny < -height_r) || (2 * ny > height_r);
        if (rej) begin
            nx = px;
            ny = py;
            nh = ph;
        end

        r.new_x       = nx[15:0];
        r.new_y       = ny[15:0];
        r.new_heading = nh[15:0];
        r.rejected    = rej;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            spacing_r   = 2560;
            front_off_r = 0;
            left_off_r  = 0;
            right_off_r = 0;
            width_r     = 36864;
            height_r    = 36864;
            max_dist_r  = 12288;
            max_corr_r  = 1024;
            expected_poses.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[4:2]))
                    REG_SENSOR_SPACING: spacing_r   = longint'($signed(pwdata[14:0]));
                    REG_FRONT_Y_OFFSET: front_off_r = longint'($signed(pwdata[14:0]));
                    REG_LEFT_X_OFFSET:  left_off_r  = longint'($signed(pwdata[14:0]));
                    REG_RIGHT_X_OFFSET: right_off_r = longint'($signed(pwdata[14:0]));
                    REG_FIELD_WIDTH:    width_r     = longint'(pwdata[15:0]);
                    REG_FIELD_HEIGHT:   height_r    = longint'(pwdata[15:0]);
                    REG_MAX_DISTANCE:   max_dist_r  = longint'(pwdata[15:0]);
                    REG_MAX_CORRECTION: max_corr_r  = longint'(pwdata[15:0]);
                    default: ;
                endcase
            end

            if (o_out_valid && !i_out_stall) begin
                if (expected_poses.size() == 0) begin
                    $error("result transaction with no input pending: x=%0d y=%0d",
                           o_out_data.new_x, o_out_data.new_y);
                    fail_count++;
                end else begin
                    want = expected_poses.pop_front();
                    checked++;
                    if (want.rejected)
                        rejected_seen++;
                    if (o_out_data.new_x !== want.new_x) begin
                        $error("new_x: expected %0d, got %0d", want.new_x, o_out_data.new_x);
                        fail_count++;
                    end
                    if (o_out_data.new_y !== want.new_y) begin
                        $error("new_y: expected %0d, got %0d", want.new_y, o_out_data.new_y);
                        fail_count++;
                    end
                    if (o_out_data.new_heading !== want.new_heading) begin
                        $error("new_heading: expected %0d, got %0d",
                               want.new_heading, o_out_data.new_heading);
                        fail_count++;
                    end
                    if (o_out_data.rejected !== want.rejected) begin
                        $error("rejected: expected %0d, got %0d",
                               want.rejected, o_out_data.rejected);
                        fail_count++;
                    end
                end
            end

            if (i_in_valid && !o_in_stall)
                expected_poses.push_back(correct_pose(i_in_data));
        end
        pending = expected_poses.size();
    end

endmodule

[bench/wall_distance_pose_corrector_tb.sv]
`timescale 1ns / 1ps

module wall_distance_pose_corrector_tb;
    import wdpc_pkg::*;

    localparam int BLEND       = 64;
    localparam int STEPS       = 14;
    localparam int LATENCY     = STEPS + 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;
    localparam int FAR         = 16383;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    t_in           i_in_data;
    logic          o_out_valid;
    logic          i_out_stall;
    t_out          o_out_data;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [AW-1:0] paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    int fail_count;
    int pending;
    int checked;
    int rejected_seen;

    // register values as last written, used to aim the frames
    int cfg_spacing;
    int cfg_front;
    int cfg_left;
    int cfg_right;
    int cfg_width;
    int cfg_height;
    int cfg_maxd;
    int cfg_corr;

    int  settings;
    int  burst_left;
    int  cycles;
    bit  no_gaps;
    bit  long_hold_req;
    bit  long_hold_done;

    wall_distance_pose_corrector #(
        .BLEND_Q8     (BLEND),
        .CORDIC_STEPS (STEPS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    pose_correction_checker #(
        .BLEND_Q8     (BLEND),
        .CORDIC_STEPS (STEPS)
    ) pose_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked),
        .rejected_seen (rejected_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Verification failed");
            $finish;
        end
    end

    // output side: stall modes that change every so often, plus one long hold-off
    initial begin : receiver
        int mode;
        int span;
        i_out_stall <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 150);
            for (int k = 0; k < span; k++) begin
                @(posedge i_clk);
                if (long_hold_req && !long_hold_done) begin
                    i_out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    long_hold_done = 1'b1;
                end
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 99) < 30);
                    2:       i_out_stall <= ($urandom_range(0, 99) < 70);
                    default: i_out_stall <= (k % 4 == 3);
                endcase
            end
        end
    end

    function automatic int spread(int amp);
        return int'($urandom_range(0, 2 * amp)) - amp;
    endfunction

    // 1/256 inch to mm, 25.4/256 = 127/1280
    function automatic logic [13:0] to_mm(int d);
        int m;
        if (d <= 0)
            return 14'd0;
        m = d * 127 / 1280;
        return (m > FAR) ? 14'(FAR) : 14'(m);
    endfunction

    // a sensor frame roughly consistent with a pose on the field
    function automatic t_in make_frame();
        t_in f;
        int  hw;
        int  hh;
        int  x;
        int  y;
        int  amp;
        int  sp;
        int  diff;
        int  avg;
        hw  = cfg_width / 2;
        hh  = cfg_height / 2;
        amp = $urandom_range(0, 1) ? cfg_corr / 2 + 1 : 2 * cfg_corr + 64;
        x   = spread(hw + 1);
        y   = spread(hh + 1);
        if ($urandom_range(0, 9) == 0)
            x = x + spread(3000);
        if ($urandom_range(0, 9) == 0)
            y = y + spread(3000);
        sp   = (cfg_spacing < 0) ? -cfg_spacing : cfg_spacing;
        diff = spread(sp + 1);
        avg  = hh - y - cfg_front + spread(amp);
        f.pose_x         = 16'(x);
        f.pose_y         = 16'(y);
        f.pose_heading   = 16'(spread(6434));
        f.front_left_mm  = to_mm(avg + diff / 2);
        f.front_right_mm = to_mm(avg - diff / 2);
        f.left_mm        = to_mm(x + hw + cfg_left + spread(amp));
        f.right_mm       = to_mm(hw - cfg_right - x + spread(amp));
        if ($urandom_range(0, 4) == 0)
            f.front_left_mm = 14'(FAR);
        if ($urandom_range(0, 4) == 0)
            f.left_mm = 14'(FAR);
        if ($urandom_range(0, 4) == 0)
            f.right_mm = 14'(FAR);
        return f;
    endfunction

    task automatic push_frame(t_in f);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= f;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic offer(int px, int py, int ph, int fl, int fr, int lm, int rm);
        t_in f;
        f.pose_x         = 16'(px);
        f.pose_y         = 16'(py);
        f.pose_heading   = 16'(ph);
        f.front_left_mm  = 14'(fl);
        f.front_right_mm = 14'(fr);
        f.left_mm        = 14'(lm);
        f.right_mm       = 14'(rm);
        push_frame(f);
    endtask

    task automatic random_frames(int n);
        t_in f;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 20)
                f = t_in'({$urandom, $urandom, $urandom, $urandom});
            else
                f = make_frame();
            push_frame(f);
        end
    endtask

    // stop sending and wait until every result transaction has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_reg_idx idx, int value);
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(int sp, int fy, int lx, int rx,
                                  int fw, int fh, int md, int mc);
        drain();
        cfg_write(REG_SENSOR_SPACING, sp);
        cfg_write(REG_FRONT_Y_OFFSET, fy);
        cfg_write(REG_LEFT_X_OFFSET, lx);
        cfg_write(REG_RIGHT_X_OFFSET, rx);
        cfg_write(REG_FIELD_WIDTH, fw);
        cfg_write(REG_FIELD_HEIGHT, fh);
        cfg_write(REG_MAX_DISTANCE, md);
        cfg_write(REG_MAX_CORRECTION, mc);
        cfg_spacing = sp;
        cfg_front   = fy;
        cfg_left    = lx;
        cfg_right   = rx;
        cfg_width   = fw;
        cfg_height  = fh;
        cfg_maxd    = md;
        cfg_corr    = mc;
        settings++;
    endtask

    initial begin : stimulus
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        cfg_spacing = 2560;
        cfg_front   = 0;
        cfg_left    = 0;
        cfg_right   = 0;
        cfg_width   = 36864;
        cfg_height  = 36864;
        cfg_maxd    = 12288;
        cfg_corr    = 1024;
        settings    = 1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: half field 18432, max correction 1024
        offer(0, 0, 0, 0, 0, 0, 0);
        offer(32767, 32767, 32767, FAR, FAR, FAR, FAR);
        offer(-32768, -32768, -32768, 0, 0, 0, 0);
        offer(-18432, 18432, 0, 0, 0, 0, FAR);
        // prediction error exactly at the limit is not taken, one less is
        offer(0, 17408, 100, 0, 0, FAR, FAR);
        offer(0, 17409, 100, 0, 0, FAR, FAR);
        offer(-17408, 0, 0, FAR, FAR, 0, FAR);
        offer(-17409, 0, 0, FAR, FAR, 0, FAR);
        offer(17408, 0, 0, FAR, FAR, FAR, 0);
        offer(17409, 0, 0, FAR, FAR, FAR, 0);
        // left taken, right too far off so left stays
        offer(-18000, 0, 0, FAR, FAR, 0, 0);
        // field edges
        offer(18432, 0, 0, FAR, FAR, FAR, FAR);
        offer(18433, 0, 0, FAR, FAR, FAR, FAR);
        offer(0, -18432, 0, FAR, FAR, FAR, FAR);
        offer(0, -18433, 0, FAR, FAR, FAR, FAR);
        // off-field pose pulled back inside by the right sensor
        offer(18440, 0, 0, FAR, FAR, FAR, 20);
        offer(18440, 0, 0, FAR, FAR, FAR, 0);
        // tilted wall both ways, heading extremes
        offer(0, 17424, 0, 200, 0, FAR, FAR);
        offer(0, 17424, 0, 0, 200, FAR, FAR);
        offer(0, 17424, -32768, 200, 0, FAR, FAR);
        offer(0, 17424, 32767, 0, 200, FAR, FAR);
        random_frames(120);

        apply_settings(-8192, 8192, -8192, 8192, 65535, 65535, 65535, 65535);
        random_frames(100);

        apply_settings(8192, -8192, 8192, -8192, 0, 0, 0, 0);
        offer(0, 0, 0, 0, 0, 0, 0);
        random_frames(40);

        // front pair off; threshold sits exactly on the 1000 mm reading
        apply_settings(0, 100, -100, 100, 36864, 24000, 10079, 2000);
        offer(-8463, 0, 0, FAR, FAR, 999, FAR);
        offer(-8453, 0, 0, FAR, FAR, 1000, FAR);
        offer(0, 0, 0, 0, 0, FAR, FAR);
        random_frames(80);

        for (int p = 0; p < 3; p++) begin
            apply_settings(int'($urandom_range(0, 16384)) - 8192,
                           int'($urandom_range(0, 16384)) - 8192,
                           int'($urandom_range(0, 16384)) - 8192,
                           int'($urandom_range(0, 16384)) - 8192,
                           $urandom_range(8192, 65535), $urandom_range(8192, 65535),
                           $urandom_range(2000, 65535), $urandom_range(0, 8000));
            random_frames(80);
        end

        // back-to-back transactions against a long output hold-off
        apply_settings(2560, 0, 0, 0, 36864, 36864, 12288, 1024);
        no_gaps       = 1'b1;
        long_hold_req = 1'b1;
        random_frames(80);
        no_gaps = 1'b0;
        drain();
        random_frames(80);

        drain();
        repeat (LATENCY + 5) @(posedge i_clk);
        $display("%0d result transactions checked over %0d register settings, %0d rejected",
                 checked, settings, rejected_seen);
        $display("directed edge cases, random frames, a %0d-cycle output hold-off, drains",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
